FILE: hdl/qau_pkg.sv
package qau_pkg;

  localparam int QAU_FRAC_BITS = 16;
  localparam int QAU_TOL_W     = 17;
  // width of an exact sum of four doubled 32x32 products
  localparam int QAU_SUM_W     = 67;
  localparam int QAU_LANES     = 4;
  localparam int QAU_TERMS     = 4;

  typedef enum logic [2:0] {
    FN_NEG   = 3'd0,
    FN_ADD   = 3'd1,
    FN_SUB   = 3'd2,
    FN_SCALE = 3'd3,
    FN_CONJ  = 3'd4,
    FN_MUL   = 3'd5,
    FN_SQMAG = 3'd6,
    FN_ROT   = 3'd7
  } qau_func_t;

  typedef logic signed [QAU_SUM_W-1:0] qau_sum_t;

  // operands and coefficients of one lane
  typedef struct packed {
    logic [QAU_TERMS-1:0][31:0] opa;
    logic [QAU_TERMS-1:0][31:0] opb;
    logic [QAU_TERMS-1:0][2:0]  k;
  } qau_lane_in_t;

  typedef struct packed {
    logic signed [31:0] val;
    logic               sat;
  } qau_clip_t;

  // product times coefficient in {-2,-1,0,1,2}
  function automatic qau_sum_t qau_kterm(input logic signed [63:0] p,
                                         input logic signed [2:0] k);
    qau_sum_t pe;
    qau_sum_t r;
    pe = QAU_SUM_W'(p);
    unique case (k)
      3'sd1:   r = pe;
      -3'sd1:  r = -pe;
      3'sd2:   r = pe <<< 1;
      -3'sd2:  r = -(pe <<< 1);
      default: r = '0;
    endcase
    return r;
  endfunction

  // round to nearest, ties up, dropping frac bits
  function automatic qau_sum_t qau_round(input qau_sum_t s, input int frac);
    qau_sum_t half;
    half = qau_sum_t'(1) <<< (frac - 1);
    return (s + half) >>> frac;
  endfunction

  function automatic qau_clip_t qau_clip(input qau_sum_t v);
    qau_clip_t r;
    qau_sum_t  maxv;
    qau_sum_t  minv;
    maxv = QAU_SUM_W'(32'sh7fffffff);
    minv = QAU_SUM_W'(32'sh80000000);
    if (v > maxv) begin
      r.val = 32'sh7fffffff;
      r.sat = 1'b1;
    end else if (v < minv) begin
      r.val = 32'sh80000000;
      r.sat = 1'b1;
    end else begin
      r.val = v[31:0];
      r.sat = 1'b0;
    end
    return r;
  endfunction

endpackage

FILE: hdl/qau_rot_prep.sv
module qau_rot_prep import qau_pkg::*; #(
  parameter int FRAC_BITS = QAU_FRAC_BITS
) (
  input  logic                      clk,
  input  logic                      en,
  input  logic [3:0][31:0]          a,
  input  logic [QAU_TOL_W-1:0]      tol,
  output logic [8:0][31:0]          m_r,
  output logic                      nu_r
);

  localparam qau_sum_t ONE = qau_sum_t'(1) <<< FRAC_BITS;

  // squares and cross products of a
  logic signed [63:0] ww_r, xx_r, yy_r, zz_r, xy_r, wz_r, xz_r, wy_r, yz_r, wx_r;
  logic signed [31:0] w, x, y, z;
  qau_sum_t           sq, dev;
  qau_sum_t [8:0]     s;
  logic [8:0][31:0]   m_nxt;

  assign w = a[0];
  assign x = a[1];
  assign y = a[2];
  assign z = a[3];

  always_ff @(posedge clk) begin
    if (en) begin
      ww_r <= w * w;
      xx_r <= x * x;
      yy_r <= y * y;
      zz_r <= z * z;
      xy_r <= x * y;
      wz_r <= w * z;
      xz_r <= x * z;
      wy_r <= w * y;
      yz_r <= y * z;
      wx_r <= w * x;
    end
  end

  always_comb begin
    s[0] = qau_kterm(yy_r, -3'sd2) + qau_kterm(zz_r, -3'sd2);
    s[1] = qau_kterm(xy_r,  3'sd2) + qau_kterm(wz_r, -3'sd2);
    s[2] = qau_kterm(xz_r,  3'sd2) + qau_kterm(wy_r,  3'sd2);
    s[3] = qau_kterm(xy_r,  3'sd2) + qau_kterm(wz_r,  3'sd2);
    s[4] = qau_kterm(xx_r, -3'sd2) + qau_kterm(zz_r, -3'sd2);
    s[5] = qau_kterm(yz_r,  3'sd2) + qau_kterm(wx_r, -3'sd2);
    s[6] = qau_kterm(xz_r,  3'sd2) + qau_kterm(wy_r, -3'sd2);
    s[7] = qau_kterm(yz_r,  3'sd2) + qau_kterm(wx_r,  3'sd2);
    s[8] = qau_kterm(xx_r, -3'sd2) + qau_kterm(yy_r, -3'sd2);
    for (int i = 0; i < 9; i++) begin
      // diagonal entries carry the added one
      if (i == 0 || i == 4 || i == 8) begin
        m_nxt[i] = qau_clip(qau_round(s[i], FRAC_BITS) + ONE).val;
      end else begin
        m_nxt[i] = qau_clip(qau_round(s[i], FRAC_BITS)).val;
      end
    end
    sq  = qau_round(qau_kterm(ww_r, 3'sd1) + qau_kterm(xx_r, 3'sd1)
                  + qau_kterm(yy_r, 3'sd1) + qau_kterm(zz_r, 3'sd1), FRAC_BITS);
    dev = sq - ONE;
    if (dev < 0) begin
      dev = -dev;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_r  <= m_nxt;
      nu_r <= dev > qau_sum_t'(tol);
    end
  end

endmodule

FILE: hdl/qau_lane.sv
module qau_lane import qau_pkg::*; #(
  parameter int FRAC_BITS = QAU_FRAC_BITS
) (
  input  logic               clk,
  input  logic               en,
  input  qau_lane_in_t       lin,
  output logic signed [31:0] res_r,
  output logic               sat_r
);

  logic signed [QAU_TERMS-1:0][63:0] p_r;
  logic        [QAU_TERMS-1:0][2:0]  k_r;
  qau_sum_t                          acc;
  qau_clip_t                         c;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < QAU_TERMS; i++) begin
        p_r[i] <= $signed(lin.opa[i]) * $signed(lin.opb[i]);
      end
      k_r <= lin.k;
    end
  end

  always_comb begin
    acc = '0;
    for (int i = 0; i < QAU_TERMS; i++) begin
      acc = acc + qau_kterm(p_r[i], $signed(k_r[i]));
    end
    c = qau_clip(qau_round(acc, FRAC_BITS));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_r <= c.val;
      sat_r <= c.sat;
    end
  end

endmodule

FILE: hdl/quaternion_arithmetic_unit.sv
// quaternion alu, signed fixed point with FRAC_BITS fraction bits
// input channel: in_valid / in_stall with func, quaternion a and operand b;
//   a transfer happens on a clock edge with in_valid high and in_stall low
// output channel: out_valid / out_stall with r_w..r_z, saturated, not_unit
// config: cfg_wr_en writes norm_tolerance from cfg_wr_data; the user writes it
//   only while idle, which the block does not enforce; one item per cycle
//   sustained unless stalled; every op goes through the same four register stages:
//   operand/square products, rotation matrix and norm check, lane products,
//   lane sum with rounding and clipping into the output register
// four lanes, one per result component, each a 4-term multiply-accumulate
// when the receiver stalls a valid result, the whole pipeline holds and
//   in_stall rises in the same cycle; a free output register lets it run
// reset clears the valid bits and loads norm_tolerance with 66
module quaternion_arithmetic_unit import qau_pkg::*; #(
  parameter int FRAC_BITS = QAU_FRAC_BITS
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [2:0]             in_func,
  input  logic signed [31:0]     in_a_w,
  input  logic signed [31:0]     in_a_x,
  input  logic signed [31:0]     in_a_y,
  input  logic signed [31:0]     in_a_z,
  input  logic signed [31:0]     in_b_w,
  input  logic signed [31:0]     in_b_x,
  input  logic signed [31:0]     in_b_y,
  input  logic signed [31:0]     in_b_z,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic signed [31:0]     out_r_w,
  output logic signed [31:0]     out_r_x,
  output logic signed [31:0]     out_r_y,
  output logic signed [31:0]     out_r_z,
  output logic                   out_saturated,
  output logic                   out_not_unit,
  input  logic                   cfg_wr_en,
  input  logic [QAU_TOL_W-1:0]   cfg_wr_data
);

  localparam logic [31:0] ONE = 32'(64'd1 << FRAC_BITS);

  logic                  en;
  logic [QAU_TOL_W-1:0]  tol_r;
  logic                  v1_r, v2_r, v3_r, out_valid_r;
  qau_func_t             op1_r, op2_r, op3_r, op4_r;
  logic [3:0][31:0]      a1_r, b1_r, a2_r, b2_r;
  logic [3:0][31:0]      a_in;
  logic [8:0][31:0]      m;
  logic                  nu;
  logic                  nu3_r, nu4_r;
  qau_lane_in_t [QAU_LANES-1:0] lin;
  logic signed [QAU_LANES-1:0][31:0] res;
  logic [QAU_LANES-1:0]  sat;

  // whole pipeline advances unless a result sits stalled at the output
  assign en       = !out_valid_r || !out_stall;
  assign in_stall = !en;
  assign a_in     = {in_a_z, in_a_y, in_a_x, in_a_w};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= QAU_TOL_W'(66);
    end else if (cfg_wr_en) begin
      tol_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      v1_r        <= in_valid;
      v2_r        <= v1_r;
      v3_r        <= v2_r;
      out_valid_r <= v3_r;
    end
  end

  // payload alongside the prep stages
  always_ff @(posedge clk) begin
    if (en) begin
      op1_r <= qau_func_t'(in_func);
      a1_r  <= a_in;
      b1_r  <= {in_b_z, in_b_y, in_b_x, in_b_w};
      op2_r <= op1_r;
      a2_r  <= a1_r;
      b2_r  <= b1_r;
      op3_r <= op2_r;
      nu3_r <= (op2_r == FN_ROT) && nu;
      op4_r <= op3_r;
      nu4_r <= nu3_r;
    end
  end

  qau_rot_prep #(.FRAC_BITS(FRAC_BITS)) u_prep (
    .clk  (clk),
    .en   (en),
    .a    (a_in),
    .tol  (tol_r),
    .m_r  (m),
    .nu_r (nu)
  );

  // per-op operand routing into the lanes; unused terms get k = 0
  always_comb begin
    for (int l = 0; l < QAU_LANES; l++) begin
      lin[l] = '0;
      unique case (op2_r)
        FN_NEG: begin
          lin[l].opa[0] = a2_r[l]; lin[l].opb[0] = ONE; lin[l].k[0] = -3'sd1;
        end
        FN_ADD: begin
          lin[l].opa[0] = a2_r[l]; lin[l].opb[0] = ONE; lin[l].k[0] = 3'sd1;
          lin[l].opa[1] = b2_r[l]; lin[l].opb[1] = ONE; lin[l].k[1] = 3'sd1;
        end
        FN_SUB: begin
          lin[l].opa[0] = a2_r[l]; lin[l].opb[0] = ONE; lin[l].k[0] = 3'sd1;
          lin[l].opa[1] = b2_r[l]; lin[l].opb[1] = ONE; lin[l].k[1] = -3'sd1;
        end
        FN_SCALE: begin
          lin[l].opa[0] = a2_r[l]; lin[l].opb[0] = b2_r[0]; lin[l].k[0] = 3'sd1;
        end
        FN_CONJ: begin
          lin[l].opa[0] = a2_r[l]; lin[l].opb[0] = ONE;
          lin[l].k[0]   = (l == 0) ? 3'sd1 : -3'sd1;
        end
        FN_MUL: begin
          unique case (l)
            0: begin
              for (int j = 0; j < 4; j++) begin
                lin[l].opa[j] = a2_r[j]; lin[l].opb[j] = b2_r[j];
                lin[l].k[j]   = (j == 0) ? 3'sd1 : -3'sd1;
              end
            end
            1: begin
              lin[l].opa = {a2_r[3], a2_r[2], b2_r[0], a2_r[0]};
              lin[l].opb = {b2_r[2], b2_r[3], a2_r[1], b2_r[1]};
              lin[l].k   = {-3'sd1, 3'sd1, 3'sd1, 3'sd1};
            end
            2: begin
              lin[l].opa = {a2_r[1], a2_r[3], b2_r[0], a2_r[0]};
              lin[l].opb = {b2_r[3], b2_r[1], a2_r[2], b2_r[2]};
              lin[l].k   = {-3'sd1, 3'sd1, 3'sd1, 3'sd1};
            end
            default: begin
              lin[l].opa = {a2_r[2], a2_r[1], b2_r[0], a2_r[0]};
              lin[l].opb = {b2_r[1], b2_r[2], a2_r[3], b2_r[3]};
              lin[l].k   = {-3'sd1, 3'sd1, 3'sd1, 3'sd1};
            end
          endcase
        end
        FN_SQMAG: begin
          if (l == 0) begin
            for (int j = 0; j < 4; j++) begin
              lin[l].opa[j] = a2_r[j]; lin[l].opb[j] = a2_r[j]; lin[l].k[j] = 3'sd1;
            end
          end
        end
        FN_ROT: begin
          // row l-1 of the rotation matrix times the vector in b; zero when not unit
          if (l != 0 && !nu) begin
            for (int j = 0; j < 3; j++) begin
              lin[l].opa[j] = m[3 * (l - 1) + j];
              lin[l].opb[j] = b2_r[j + 1];
              lin[l].k[j]   = 3'sd1;
            end
          end
        end
        default: lin[l] = '0;
      endcase
    end
  end

  for (genvar g = 0; g < QAU_LANES; g++) begin : g_lane
    qau_lane #(.FRAC_BITS(FRAC_BITS)) u_lane (
      .clk   (clk),
      .en    (en),
      .lin   (lin[g]),
      .res_r (res[g]),
      .sat_r (sat[g])
    );
  end

  // merge the lane results
  assign out_valid     = out_valid_r;
  assign out_r_w       = res[0];
  assign out_r_x       = res[1];
  assign out_r_y       = res[2];
  assign out_r_z       = res[3];
  assign out_saturated = |sat;
  assign out_not_unit  = nu4_r;

  a_nu_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_not_unit |-> out_r_w == 0 && out_r_x == 0 && out_r_y == 0
      && out_r_z == 0 && !out_saturated)
    else $error("not_unit result carries data");

  a_nu_only_rot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && op4_r != FN_ROT |-> !out_not_unit)
    else $error("not_unit outside rotate");

  a_rot_w_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && op4_r == FN_ROT |-> out_r_w == 0)
    else $error("rotate gave nonzero w");

  a_sqmag_vec_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && op4_r == FN_SQMAG |-> out_r_x == 0 && out_r_y == 0 && out_r_z == 0)
    else $error("sqmag gave nonzero vector part");

endmodule

FILE: dv/qau_checker.sv
`timescale 1ns / 100ps
module qau_checker import qau_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [2:0]         in_func,
  input  logic signed [31:0] in_a_w,
  input  logic signed [31:0] in_a_x,
  input  logic signed [31:0] in_a_y,
  input  logic signed [31:0] in_a_z,
  input  logic signed [31:0] in_b_w,
  input  logic signed [31:0] in_b_x,
  input  logic signed [31:0] in_b_y,
  input  logic signed [31:0] in_b_z,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic signed [31:0] out_r_w,
  input  logic signed [31:0] out_r_x,
  input  logic signed [31:0] out_r_y,
  input  logic signed [31:0] out_r_z,
  input  logic               out_saturated,
  input  logic               out_not_unit,
  input  logic               cfg_wr_en,
  input  logic [16:0]        cfg_wr_data,
  output int                 fail_count,
  output int                 pending
);

  typedef logic signed [127:0] wide_t;

  typedef struct packed {
    logic signed [31:0] w;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic               sat;
    logic               nu;
  } qres_t;

  qres_t      quat_results_q[$];
  logic [16:0] tolerance;

  function automatic wide_t fx_round(input wide_t s);
    return (s + (wide_t'(1) <<< (QAU_FRAC_BITS - 1))) >>> QAU_FRAC_BITS;
  endfunction

  function automatic logic signed [31:0] clip(input wide_t v, inout logic flag);
    if (v > wide_t'(32'sh7fffffff)) begin
      flag = 1'b1;
      return 32'sh7fffffff;
    end
    if (v < wide_t'(-64'sd2147483648)) begin
      flag = 1'b1;
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  function automatic qres_t quat_compute(input logic [2:0] f, input wide_t a[4],
                                         input wide_t b[4], input logic [16:0] tol);
    wide_t r[4];
    wide_t m[9];
    wide_t one, sq, dev;
    logic  sat, dummy;
    qres_t o;
    one = wide_t'(1) <<< QAU_FRAC_BITS;
    sat = 1'b0;
    dummy = 1'b0;
    o = '0;
    for (int i = 0; i < 4; i++) r[i] = 0;
    case (qau_func_t'(f))
      FN_NEG:   for (int i = 0; i < 4; i++) r[i] = -a[i];
      FN_ADD:   for (int i = 0; i < 4; i++) r[i] = a[i] + b[i];
      FN_SUB:   for (int i = 0; i < 4; i++) r[i] = a[i] - b[i];
      FN_SCALE: for (int i = 0; i < 4; i++) r[i] = fx_round(a[i] * b[0]);
      FN_CONJ: begin
        r[0] = a[0];
        for (int i = 1; i < 4; i++) r[i] = -a[i];
      end
      FN_MUL: begin
        r[0] = fx_round(a[0]*b[0] - a[1]*b[1] - a[2]*b[2] - a[3]*b[3]);
        r[1] = fx_round(a[0]*b[1] + b[0]*a[1] + a[2]*b[3] - a[3]*b[2]);
        r[2] = fx_round(a[0]*b[2] + b[0]*a[2] + a[3]*b[1] - a[1]*b[3]);
        r[3] = fx_round(a[0]*b[3] + b[0]*a[3] + a[1]*b[2] - a[2]*b[1]);
      end
      default: begin
        sq = fx_round(a[0]*a[0] + a[1]*a[1] + a[2]*a[2] + a[3]*a[3]);
        if (qau_func_t'(f) == FN_SQMAG) begin
          r[0] = sq;
        end else begin
          dev = sq - one;
          if (dev < 0) dev = -dev;
          if (dev > wide_t'(tol)) begin
            o.nu = 1'b1;
            return o;
          end
          // rotation matrix from unit a = (w, x, y, z)
          m[0] = one + fx_round(-2*a[2]*a[2] - 2*a[3]*a[3]);
          m[1] = fx_round(2*a[1]*a[2] - 2*a[0]*a[3]);
          m[2] = fx_round(2*a[1]*a[3] + 2*a[0]*a[2]);
          m[3] = fx_round(2*a[1]*a[2] + 2*a[0]*a[3]);
          m[4] = one + fx_round(-2*a[1]*a[1] - 2*a[3]*a[3]);
          m[5] = fx_round(2*a[2]*a[3] - 2*a[0]*a[1]);
          m[6] = fx_round(2*a[1]*a[3] - 2*a[0]*a[2]);
          m[7] = fx_round(2*a[2]*a[3] + 2*a[0]*a[1]);
          m[8] = one + fx_round(-2*a[1]*a[1] - 2*a[2]*a[2]);
          for (int i = 0; i < 9; i++) m[i] = clip(m[i], dummy);
          for (int i = 0; i < 3; i++)
            r[1+i] = fx_round(m[3*i]*b[1] + m[3*i+1]*b[2] + m[3*i+2]*b[3]);
        end
      end
    endcase
    o.w = clip(r[0], sat);
    o.x = clip(r[1], sat);
    o.y = clip(r[2], sat);
    o.z = clip(r[3], sat);
    o.sat = sat;
    return o;
  endfunction

  assign pending = quat_results_q.size();

  always @(posedge clk) begin
    wide_t a[4];
    wide_t b[4];
    qres_t e, got;
    if (!rst_n) begin
      tolerance <= 17'd66;
      fail_count <= 0;
    end else begin
      if (cfg_wr_en) tolerance <= cfg_wr_data;
      if (in_valid && !in_stall) begin
        a[0] = in_a_w; a[1] = in_a_x; a[2] = in_a_y; a[3] = in_a_z;
        b[0] = in_b_w; b[1] = in_b_x; b[2] = in_b_y; b[3] = in_b_z;
        quat_results_q.push_back(quat_compute(in_func, a, b, tolerance));
      end
      if (out_valid && !out_stall) begin
        got = {out_r_w, out_r_x, out_r_y, out_r_z, out_saturated, out_not_unit};
        if (quat_results_q.size() == 0) begin
          if (fail_count < 10) $display("error: unexpected result %h", got);
          fail_count <= fail_count + 1;
        end else begin
          e = quat_results_q.pop_front();
          if (got !== e) begin
            if (fail_count < 10)
              $display("error: exp w=%h x=%h y=%h z=%h s=%b n=%b got w=%h x=%h y=%h z=%h s=%b n=%b",
                       e.w, e.x, e.y, e.z, e.sat, e.nu,
                       got.w, got.x, got.y, got.z, got.sat, got.nu);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

endmodule

FILE: dv/tb.sv
`timescale 1ns / 100ps
module tb;
  import qau_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [2:0] in_func = '0;
  logic signed [31:0] in_a_w = '0, in_a_x = '0, in_a_y = '0, in_a_z = '0;
  logic signed [31:0] in_b_w = '0, in_b_x = '0, in_b_y = '0, in_b_z = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [31:0] out_r_w, out_r_x, out_r_y, out_r_z;
  logic out_saturated, out_not_unit;
  logic cfg_wr_en = 1'b0;
  logic [16:0] cfg_wr_data = '0;
  int fail_count, pending;
  int cycle_count = 0;
  // idling stops for the last part of the run
  bit quiet_tail = 1'b0;
  // receiver holds off for a long stretch while this is set
  bit hold_off = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  quaternion_arithmetic_unit uut (.*);

  qau_checker chk (.*);

  // generous limit: ~1400 items, idle bursts on both sides, hold-offs
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 200000) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // receiver: random stall bursts, one long hold-off on request
  initial begin
    int n;
    forever begin
      @(posedge clk);
      if (hold_off) begin
        out_stall <= 1'b1;
        for (int i = 0; i < 60; i++) @(posedge clk);
        hold_off = 1'b0;
        out_stall <= 1'b0;
      end else if (!quiet_tail && $urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, 5);
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  function automatic logic signed [31:0] rand_fixed();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return $signed($urandom_range(0, 262143)) - 131072;
      2: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
      3: return $signed($urandom_range(0, 1024)) - 512;
      default: return $signed($urandom_range(0, 4194303)) - 2097152;
    endcase
  endfunction

  // one transfer on the input channel, then maybe an idle burst
  task automatic send_quat(input logic [2:0] f, input logic signed [31:0] aw, ax, ay, az,
                           input logic signed [31:0] bw, bx, by, bz);
    in_valid <= 1'b1;
    in_func <= f;
    in_a_w <= aw; in_a_x <= ax; in_a_y <= ay; in_a_z <= az;
    in_b_w <= bw; in_b_x <= bx; in_b_y <= by; in_b_z <= bz;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (!quiet_tail && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  endtask

  // near-unit quaternion: a rotation about a random axis with some noise
  task automatic send_rotation(input int noise);
    real ang, ux, uy, uz, nrm, s;
    ang = ($urandom_range(0, 62831) / 10000.0);
    ux = $urandom_range(0, 2000) - 1000.0;
    uy = $urandom_range(0, 2000) - 1000.0;
    uz = $urandom_range(0, 2000) - 1000.0 + 0.5;
    nrm = $sqrt(ux*ux + uy*uy + uz*uz);
    s = $sin(ang / 2.0) / nrm;
    send_quat(FN_ROT,
              $rtoi($cos(ang / 2.0) * 65536.0) + $signed($urandom_range(0, 2*noise)) - noise,
              $rtoi(ux * s * 65536.0), $rtoi(uy * s * 65536.0), $rtoi(uz * s * 65536.0),
              rand_fixed(), rand_fixed(), rand_fixed(), rand_fixed());
  endtask

  // drain all results and the pipeline before touching the register
  task automatic write_tolerance(input logic [16:0] v);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic random_phase(input int count);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 2) == 0)
        send_rotation($urandom_range(0, 1) ? 40 : $urandom_range(0, 2000));
      else
        send_quat(3'($urandom_range(0, 7)), rand_fixed(), rand_fixed(), rand_fixed(),
                  rand_fixed(), rand_fixed(), rand_fixed(), rand_fixed(), rand_fixed());
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // directed: every op at field extremes
    for (int f = 0; f < 8; f++) begin
      send_quat(3'(f), 32'sh80000000, 32'sh7fffffff, 32'sh00010000, -32'sh00010000,
                32'sh7fffffff, 32'sh80000000, 32'sh00008000, 32'shffff8000);
    end
    send_quat(FN_NEG, 32'sh80000000, 0, 0, 0, 0, 0, 0, 0);
    send_quat(FN_SQMAG, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 0, 0, 0, 0);
    send_quat(FN_MUL, 32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh80000000,
              32'sh80000000, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff);
    send_quat(FN_SCALE, 32'sh00018000, -32'sh00008000, 1, -1, 32'sh00008000, 0, 0, 0);
    // identity rotation, just outside tolerance, zero quaternion
    send_quat(FN_ROT, 32'sh00010000, 0, 0, 0, 0, 32'sh7fffffff, 32'sh80000000, 32'sh00010000);
    send_quat(FN_ROT, 32'sh00010043, 0, 0, 0, 0, 32'sh00010000, 0, 0);
    send_quat(FN_ROT, 32'sh00010042, 0, 0, 0, 0, 32'sh00010000, 0, 0);
    send_quat(FN_ROT, 0, 0, 0, 0, 0, 1, 2, 3);
    send_quat(FN_ROT, 0, 32'sh0000b505, 32'sh0000b505, 0, 0, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff);
    random_phase(300);
    // long receiver hold-off with the sender still offering
    hold_off = 1'b1;
    random_phase(100);
    write_tolerance(17'd0);
    send_quat(FN_ROT, 32'sh00010000, 0, 0, 0, 0, 5, 6, 7);
    random_phase(250);
    write_tolerance(17'h1ffff);
    send_quat(FN_ROT, 0, 0, 0, 0, 0, 5, 6, 7);
    random_phase(250);
    write_tolerance(17'd65536);
    random_phase(200);
    write_tolerance(17'd1000);
    random_phase(100);
    quiet_tail = 1'b1;
    random_phase(130);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
